FILE: rtl/core/pva_pkg.sv
`timescale 1ns / 1ps
package pva_pkg;

  // Fixed field widths of the keyboard and oscillator beats
  localparam int KeyW      = 15;
  localparam int NoteW     = 7;
  localparam int VpnW      = 5;
  localparam int OscOutW   = 4;
  localparam int CountOutW = 5;
  localparam int KeyIdxW   = 4;

  // Note range and window limits
  localparam int NumNotes  = 128;
  localparam int MaxBase   = NumNotes - KeyW;
  localparam int BaseReset = 50;
  localparam int VpnReset  = 1;

  // Oscillator pool
  localparam int NumOscDef = 16;
  localparam int MaxEmit   = 16;

  // APB
  localparam int PaddrW = 3;
  localparam int PdataW = 32;

  typedef enum logic [0:0] {
    REG_VOICES_PER_NOTE = 1'b0
  } pva_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FREE_RD,
    ST_FREE_CHK,
    ST_SCAN,
    ST_ASSIGN,
    ST_EMIT_RD,
    ST_EMIT_WR
  } pva_state_e;

  typedef struct packed {
    logic [KeyW-1:0] key_mask;
    logic            page_up;
    logic            page_down;
  } pva_in_t;

  typedef struct packed {
    logic [OscOutW-1:0]   osc_index;
    logic [NoteW-1:0]     osc_note;
    logic                 osc_active;
    logic [CountOutW-1:0] active_count;
    logic [NoteW-1:0]     window_base;
    logic                 last;
  } pva_out_t;

  // Window status seen by the allocator
  typedef struct packed {
    logic [NoteW-1:0] base;
    logic [KeyW-1:0]  new_mask;
  } pva_win_t;

endpackage

FILE: rtl/core/pva_note_mem.sv
`timescale 1ns / 1ps
module pva_note_mem #(
  parameter int Depth = 16,
  parameter int Width = 7
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/pva_window.sv
`timescale 1ns / 1ps
module pva_window (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           frame_i,
  input  pva_pkg::pva_in_t               in_data_i,
  input  logic [pva_pkg::NoteW-1:0]      note_i,
  output pva_pkg::pva_win_t              win_o,
  output logic                           release_o
);
  import pva_pkg::*;

  logic [NoteW-1:0] base_q, base_d, prev_base_q;
  logic [KeyW-1:0]  keys_q, prev_keys_q;
  logic [7:0]       b_up, b_mv;
  logic [7:0]       dn_now, dn_prev;
  logic             now_hit, prev_hit;
  logic [KeyW-1:0]  new_mask;

  // Page moves, then clamp to the legal window range
  always_comb begin
    b_up = 8'(base_q) + 8'(in_data_i.page_up);
    if (in_data_i.page_down && (b_up == 8'd0)) begin
      b_mv = 8'd0;
    end else begin
      b_mv = b_up - 8'(in_data_i.page_down);
    end
    if (b_mv > 8'(MaxBase)) begin
      base_d = NoteW'(MaxBase);
    end else begin
      base_d = b_mv[NoteW-1:0];
    end
  end

  // Current and previous frame; previous frame stands in for the held map
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= NoteW'(BaseReset);
      keys_q      <= '0;
      prev_base_q <= '0;
      prev_keys_q <= '0;
    end else if (frame_i) begin
      base_q      <= base_d;
      keys_q      <= in_data_i.key_mask;
      prev_base_q <= base_q;
      prev_keys_q <= keys_q;
    end
  end

  // Newly pressed window keys: pressed now, not held last frame
  always_comb begin
    logic [7:0] off;
    for (int k = 0; k < KeyW; k++) begin
      off = 8'(base_q) + 8'(k) - 8'(prev_base_q);
      new_mask[k] = keys_q[k] &&
                    !((off < 8'(KeyW)) && prev_keys_q[off[KeyIdxW-1:0]]);
    end
  end

  // Release test for the note read from an oscillator
  always_comb begin
    dn_now   = 8'(note_i) - 8'(base_q);
    dn_prev  = 8'(note_i) - 8'(prev_base_q);
    now_hit  = (dn_now < 8'(KeyW)) && keys_q[dn_now[KeyIdxW-1:0]];
    prev_hit = (dn_prev < 8'(KeyW)) && prev_keys_q[dn_prev[KeyIdxW-1:0]];
  end

  assign release_o      = prev_hit && !now_hit;
  assign win_o.base     = base_q;
  assign win_o.new_mask = new_mask;

endmodule

FILE: rtl/core/pva_alloc.sv
`timescale 1ns / 1ps
module pva_alloc #(
  parameter int NumOsc = pva_pkg::NumOscDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pva_pkg::pva_out_t             out_data_o,
  input  logic [pva_pkg::VpnW-1:0]      vpn_i,
  input  pva_pkg::pva_win_t             win_i,
  input  logic                          release_i,
  output logic                          mem_we_o,
  output logic [$clog2(NumOsc)-1:0]     mem_waddr_o,
  output logic [pva_pkg::NoteW-1:0]     mem_wdata_o,
  output logic [$clog2(NumOsc)-1:0]     mem_raddr_o,
  input  logic [pva_pkg::NoteW-1:0]     mem_rdata_i
);
  import pva_pkg::*;

  localparam int IdxW = $clog2(NumOsc);
  localparam int CntW = $clog2(NumOsc + 1);
  localparam int Emit = (NumOsc < MaxEmit) ? NumOsc : MaxEmit;

  pva_state_e          state_q, state_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [IdxW-1:0]     ptr_q, ptr_d, ptr_inc;
  logic [KeyIdxW-1:0]  key_q, key_d;
  logic [VpnW-1:0]     voice_q, voice_d;
  logic [CntW-1:0]     tries_q, tries_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [NumOsc-1:0]   valid_q, valid_d;
  pva_out_t            out_q, out_d;
  logic                out_valid_q, out_valid_d;
  logic                load;
  logic [7:0]          cnt8;
  logic [NoteW-1:0]    new_note;

  assign ptr_inc  = (ptr_q == IdxW'(NumOsc - 1)) ? '0 : ptr_q + 1'b1;
  assign new_note = win_i.base + NoteW'(key_q);
  assign cnt8     = 8'(count_q);

  // Sequencer: free pass, key scan with round robin search, table readout
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    ptr_d       = ptr_q;
    key_d       = key_q;
    voice_d     = voice_q;
    tries_d     = tries_q;
    count_d     = count_q;
    valid_d     = valid_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    load        = 1'b0;
    mem_we_o    = 1'b0;
    in_ready_o  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          idx_d   = '0;
          state_d = ST_FREE_RD;
        end
      end
      ST_FREE_RD: begin
        state_d = ST_FREE_CHK;
      end
      ST_FREE_CHK: begin
        if (valid_q[idx_q] && release_i) begin
          valid_d[idx_q] = 1'b0;
          count_d        = count_q - 1'b1;
        end
        if (idx_q == IdxW'(NumOsc - 1)) begin
          key_d   = '0;
          state_d = ST_SCAN;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_FREE_RD;
        end
      end
      ST_SCAN: begin
        if (win_i.new_mask[key_q] && (vpn_i != '0)) begin
          voice_d = '0;
          tries_d = '0;
          state_d = ST_ASSIGN;
        end else if (key_q == KeyIdxW'(KeyW - 1)) begin
          idx_d   = '0;
          state_d = ST_EMIT_RD;
        end else begin
          key_d = key_q + 1'b1;
        end
      end
      ST_ASSIGN: begin
        if (valid_q[ptr_q] && (tries_q != CntW'(NumOsc))) begin
          // slot busy: step the pointer
          ptr_d   = ptr_inc;
          tries_d = tries_q + 1'b1;
        end else begin
          // take a free slot, or steal the one at the pointer
          mem_we_o = 1'b1;
          if (!valid_q[ptr_q]) begin
            count_d = count_q + 1'b1;
          end
          valid_d[ptr_q] = 1'b1;
          ptr_d          = ptr_inc;
          tries_d        = '0;
          if ((6'(voice_q) + 6'd1) == 6'(vpn_i)) begin
            if (key_q == KeyIdxW'(KeyW - 1)) begin
              idx_d   = '0;
              state_d = ST_EMIT_RD;
            end else begin
              key_d   = key_q + 1'b1;
              state_d = ST_SCAN;
            end
          end else begin
            voice_d = voice_q + 1'b1;
          end
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (!out_valid_q || out_ready_i) begin
          load                  = 1'b1;
          out_valid_d           = 1'b1;
          out_d.osc_index       = OscOutW'(idx_q);
          out_d.osc_active      = valid_q[idx_q];
          out_d.osc_note        = valid_q[idx_q] ? mem_rdata_i : '0;
          out_d.active_count    = (cnt8 > 8'd31) ? 5'd31 : cnt8[CountOutW-1:0];
          out_d.window_base     = win_i.base;
          out_d.last            = (idx_q == IdxW'(Emit - 1));
          if (idx_q == IdxW'(Emit - 1)) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control and bookkeeping registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      ptr_q       <= '0;
      key_q       <= '0;
      voice_q     <= '0;
      tries_q     <= '0;
      count_q     <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      ptr_q       <= ptr_d;
      key_q       <= key_d;
      voice_q     <= voice_d;
      tries_q     <= tries_d;
      count_q     <= count_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output beat register
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign mem_waddr_o = ptr_q;
  assign mem_wdata_o = new_note;
  assign mem_raddr_o = idx_q;

`ifndef SYNTH
  // Active counter tracks the valid bits
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == $countones(valid_q))
    else $error("active count out of step with valid bits");

  // A written slot is marked valid
  a_write_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |=> valid_q[$past(ptr_q)])
    else $error("note written to slot left invalid");

  // Search never runs past one full lap
  a_tries_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tries_q <= CntW'(NumOsc))
    else $error("search ran past the pool");

  // Last beat of a frame returns to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && out_d.last) |=> (state_q == ST_IDLE))
    else $error("no return to idle after last beat");

  // New frames only enter when no beat is being built
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> !load && !mem_we_o)
    else $error("frame accepted during a frame");
`endif

endmodule

FILE: rtl/core/polyphonic_voice_allocator.sv
`timescale 1ns / 1ps
// Polyphonic voice allocator.
// Input channel (in_valid_i/in_ready_o/in_data_i): one beat per keyboard scan
// frame, 15 window keys plus page up and page down.
// Output channel (out_valid_o/out_ready_i/out_data_o): per frame, one beat per
// oscillator slot 0 .. min(16, NumOsc)-1 in slot order, last set on the final.
// APB port: register 0 at byte 0 is voices_per_note (5 bits, reset 1).
// A frame runs a release pass over the note memory, a key scan, an assign
// step per voice with busy slots skipped, and a read and a write state per
// emitted beat. The sequencer returns to idle before the next frame is taken.
// The registered note memory read sets the release and readout pace: each
// slot passes through a read state before its check or emit state.
// A frame is taken only when the previous one is fully built; the last beat
// may still sit in the output register while the next frame is taken.
// Receiver stalls hold the output register and pause the readout.
// Reset: window base 50, no keys held, all oscillators free, pointer at 0,
// voices_per_note 1; the note memory is not cleared.
module polyphonic_voice_allocator #(
  parameter int NumOsc = pva_pkg::NumOscDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  pva_pkg::pva_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output pva_pkg::pva_out_t            out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pva_pkg::PaddrW-1:0]   paddr,
  input  logic [pva_pkg::PdataW-1:0]   pwdata,
  output logic [pva_pkg::PdataW-1:0]   prdata,
  output logic                         pready
);
  import pva_pkg::*;

  localparam int IdxW = $clog2(NumOsc);

  logic [VpnW-1:0]  vpn_q;
  logic             frame;
  pva_win_t         win;
  logic             rel;
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr, mem_raddr;
  logic [NoteW-1:0] mem_wdata, mem_rdata;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vpn_q <= VpnW'(VpnReset);
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_VOICES_PER_NOTE)) begin
      vpn_q <= pwdata[VpnW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_VOICES_PER_NOTE) begin
      prdata = PdataW'(vpn_q);
    end
  end

  assign frame = in_valid_i && in_ready_o;

  pva_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .frame_i   (frame),
    .in_data_i (in_data_i),
    .note_i    (mem_rdata),
    .win_o     (win),
    .release_o (rel)
  );

  pva_note_mem #(
    .Depth (NumOsc),
    .Width (NoteW)
  ) u_note_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pva_alloc #(
    .NumOsc (NumOsc)
  ) u_alloc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .vpn_i       (vpn_q),
    .win_i       (win),
    .release_i   (rel),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule
